// File: design/wrcp_pkg.sv
// Package for the WAV/RIFF chunk parser: tag constants, chunk kinds,
// status codes and the result record type.
// No dependencies.
package wrcp_pkg;

   localparam int unsigned PosWidth = 6;   // saturating byte count, enough to tell 44
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueueAddrWidth = 2;
   localparam int unsigned QueueCountWidth = 3;
   localparam int unsigned DataWidth = 112; // 107 payload bits filled to whole bytes

   localparam logic [PosWidth-1:0] PosMax = '1;
   localparam logic [PosWidth-1:0] PosTagEnd = 6'd12;
   localparam logic [PosWidth-1:0] PosRiffEnd = 6'd4;
   localparam logic [PosWidth-1:0] PosWaveStart = 6'd8;
   localparam logic [PosWidth-1:0] MinFileBytes = 6'd44;

   localparam logic [31:0] TagFmt = 32'h666D_7420;
   localparam logic [31:0] TagSmpl = 32'h736D_706C;
   localparam logic [31:0] TagData = 32'h6461_7461;

   localparam logic [31:0] FmtMinLen = 32'd16;
   localparam logic [31:0] SmplMinLen = 32'd60;
   localparam logic [31:0] FmtRateOff = 32'd7;
   localparam logic [31:0] SmplCountOff = 32'd31;
   localparam logic [31:0] SmplBeginOff = 32'd47;
   localparam logic [31:0] SmplEndOff = 32'd51;

   localparam logic [7:0] PcmBias = 8'h80;

   localparam logic [7:0] RiffTag [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
   localparam logic [7:0] WaveTag [4] = '{8'h57, 8'h41, 8'h56, 8'h45};

   typedef enum logic [1:0] {
      KIND_OTHER,
      KIND_FMT,
      KIND_SMPL,
      KIND_DATA
   } chunk_kind_type;

   typedef enum logic [1:0] {
      STAT_OK,
      STAT_SHORT,
      STAT_BAD_HDR,
      STAT_NO_DATA
   } status_type;

   typedef enum logic {
      RES_SAMPLE,
      RES_SUMMARY
   } res_kind_type;

   typedef struct packed {
      status_type   status;
      logic         looping;
      logic [31:0]  loop_finish;
      logic [31:0]  loop_begin;
      logic [31:0]  rate_hz;
      logic         chunk_first;
      logic [7:0]   pcm_value;
      res_kind_type kind;
   } result_type;

endpackage

// File: design/wav_riff_chunk_parser.sv
// WAV/RIFF chunk parser top level: header check, chunk walk, field capture
// and a four-entry result queue. Depends on wrcp_pkg.
//
// Usage: feed the file one byte per item on req_tdata, with req_tlast high
// on the final byte. Bytes of each "data" chunk body come back as signed
// samples (byte minus 128) with rsp_tuser[0] low; rsp_tuser[1] marks the
// first sample of each data chunk. After the final byte a summary item
// follows (rsp_tuser[0] high) with sample rate, first loop start and end,
// looping flag and status (ok, under 44 bytes, bad header, no data).
// Samples that come out before a file proves short or empty are to be
// dropped by the consumer based on the summary status.
// Each result is queued as its byte is accepted and goes out on rsp in order.
// Throughput: one byte per cycle while req_tready is high; the final byte
// of a file that also carries a sample yields two results, both queued
// together. req_tready is a registered flag that stays high while the queue
// has room for two more results, so a stalled receiver backs up into the
// queue and then holds the sender. Synchronous reset empties the queue and
// returns the parser to the start of a file; after each summary the parser
// returns to that same state for the next file.
module wav_riff_chunk_parser
   import wrcp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] in_byte
   input  logic                 req_tlast,   // in_last
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [7:0] pcm_value, [39:8] rate_hz, [71:40] loop_begin, [103:72] loop_finish,
   // [104] looping, [106:105] status, [111:107] zero
   output logic [DataWidth-1:0] rsp_tdata,
   output logic [1:0]           rsp_tuser    // [0] kind, [1] chunk_first
);

   // parser state
   logic [PosWidth-1:0] pos_ff, pos_in;
   logic                header_ok_ff, header_ok_in;
   logic [31:0]         tag_ff, tag_in;
   logic [31:0]         len_ff, len_in;
   logic [31:0]         offset_ff, offset_in;
   chunk_kind_type      kind_ff, kind_in;
   logic                in_body_ff, in_body_in;
   logic                pad_ff, pad_in;
   logic                loop_nz_ff, loop_nz_in;
   logic [31:0]         rate_ff, rate_in;
   logic [31:0]         begin_ff, begin_in;
   logic [31:0]         finish_ff, finish_in;
   logic                looping_ff, looping_in;
   logic                data_seen_ff, data_seen_in;
   logic [31:0]         acc_ff, acc_in;
   logic [31:0]         hold_ff, hold_in;

   // result queue
   result_type                 queue_ff [QueueDepth];
   logic [QueueAddrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QueueAddrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QueueCountWidth-1:0] count_ff, count_in;
   logic                       ready_ff, ready_in;

   logic                       accept;
   logic                       drain;
   logic                       emit;
   logic                       first;
   logic [QueueCountWidth-1:0] n_wr;
   result_type                 sample_res;
   result_type                 summary_res;
   result_type                 wr0_res;
   status_type                 status;

   assign req_tready = ready_ff;
   assign accept = req_tvalid && ready_ff;
   assign drain = rsp_tvalid && rsp_tready;

   always_comb begin
      pos_in = pos_ff;
      header_ok_in = header_ok_ff;
      tag_in = tag_ff;
      len_in = len_ff;
      offset_in = offset_ff;
      kind_in = kind_ff;
      in_body_in = in_body_ff;
      pad_in = pad_ff;
      loop_nz_in = loop_nz_ff;
      rate_in = rate_ff;
      begin_in = begin_ff;
      finish_in = finish_ff;
      looping_in = looping_ff;
      data_seen_in = data_seen_ff;
      acc_in = acc_ff;
      hold_in = hold_ff;
      emit = 1'b0;
      first = 1'b0;

      if (pos_ff < PosTagEnd) begin
         if (pos_ff < PosRiffEnd) begin
            if (req_tdata != RiffTag[pos_ff[1:0]]) header_ok_in = 1'b0;
         end else if (pos_ff >= PosWaveStart) begin
            if (req_tdata != WaveTag[pos_ff[1:0]]) header_ok_in = 1'b0;
         end
      end else if (header_ok_ff) begin
         if (pad_ff) begin
            pad_in = 1'b0;
         end else if (!in_body_ff) begin
            // chunk header: four tag bytes, then four little-endian size bytes
            if (!offset_ff[2]) tag_in = {tag_ff[23:0], req_tdata};
            else len_in = {req_tdata, len_ff[31:8]};
            offset_in = offset_ff + 32'd1;
            if (offset_ff[2:0] == 3'd7) begin
               offset_in = '0;
               if (tag_ff == TagFmt) kind_in = KIND_FMT;
               else if (tag_ff == TagSmpl) kind_in = KIND_SMPL;
               else if (tag_ff == TagData) kind_in = KIND_DATA;
               else kind_in = KIND_OTHER;
               if (tag_ff == TagData) data_seen_in = 1'b0;
               in_body_in = (len_in != '0);
            end
         end else begin
            acc_in = {req_tdata, acc_ff[31:8]};
            unique case (kind_ff)
               KIND_FMT: begin
                  if (len_ff >= FmtMinLen && offset_ff == FmtRateOff) rate_in = acc_in;
               end
               KIND_SMPL: begin
                  if (len_ff >= SmplMinLen) begin
                     if (offset_ff == SmplCountOff) loop_nz_in = (acc_in != '0);
                     if (offset_ff == SmplBeginOff) hold_in = acc_in;
                     if (offset_ff == SmplEndOff && loop_nz_ff) begin
                        begin_in = hold_ff;
                        finish_in = acc_in;
                        looping_in = 1'b1;
                     end
                  end
               end
               KIND_DATA: begin
                  emit = 1'b1;
                  first = (offset_ff == '0);
                  data_seen_in = 1'b1;
               end
               default: begin
               end
            endcase
            if (offset_ff == len_ff - 32'd1) begin
               in_body_in = 1'b0;
               offset_in = '0;
               pad_in = len_ff[0];
            end else begin
               offset_in = offset_ff + 32'd1;
            end
         end
      end
      if (pos_ff != PosMax) pos_in = pos_ff + 1'b1;

      if (pos_in < MinFileBytes) status = STAT_SHORT;
      else if (!header_ok_in) status = STAT_BAD_HDR;
      else if (!data_seen_in) status = STAT_NO_DATA;
      else status = STAT_OK;

      sample_res = '0;
      sample_res.kind = RES_SAMPLE;
      sample_res.pcm_value = req_tdata ^ PcmBias;
      sample_res.chunk_first = first;

      summary_res = '0;
      summary_res.kind = RES_SUMMARY;
      summary_res.rate_hz = rate_in;
      summary_res.loop_begin = begin_in;
      summary_res.loop_finish = finish_in;
      summary_res.looping = looping_in;
      summary_res.status = status;

      wr0_res = emit ? sample_res : summary_res;

      // end of file: start over for the next one
      if (req_tlast) begin
         pos_in = '0;
         header_ok_in = 1'b1;
         offset_in = '0;
         kind_in = KIND_OTHER;
         in_body_in = 1'b0;
         pad_in = 1'b0;
         loop_nz_in = 1'b0;
         rate_in = '0;
         begin_in = '0;
         finish_in = '0;
         looping_in = 1'b0;
         data_seen_in = 1'b0;
      end

      n_wr = '0;
      if (accept) n_wr = QueueCountWidth'(emit) + QueueCountWidth'(req_tlast);
      wr_ptr_in = wr_ptr_ff + n_wr[QueueAddrWidth-1:0];
      rd_ptr_in = rd_ptr_ff + QueueAddrWidth'(drain);
      count_in = count_ff + n_wr - QueueCountWidth'(drain);
      ready_in = (count_in <= QueueCountWidth'(QueueDepth - 2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         header_ok_ff <= 1'b1;
         offset_ff <= '0;
         kind_ff <= KIND_OTHER;
         in_body_ff <= 1'b0;
         pad_ff <= 1'b0;
         loop_nz_ff <= 1'b0;
         rate_ff <= '0;
         begin_ff <= '0;
         finish_ff <= '0;
         looping_ff <= 1'b0;
         data_seen_ff <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
         ready_ff <= 1'b0;
      end else begin
         if (accept) begin
            pos_ff <= pos_in;
            header_ok_ff <= header_ok_in;
            offset_ff <= offset_in;
            kind_ff <= kind_in;
            in_body_ff <= in_body_in;
            pad_ff <= pad_in;
            loop_nz_ff <= loop_nz_in;
            rate_ff <= rate_in;
            begin_ff <= begin_in;
            finish_ff <= finish_in;
            looping_ff <= looping_in;
            data_seen_ff <= data_seen_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
         ready_ff <= ready_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         tag_ff <= tag_in;
         len_ff <= len_in;
         acc_ff <= acc_in;
         hold_ff <= hold_in;
         if (n_wr != '0) queue_ff[wr_ptr_ff] <= wr0_res;
         if (emit && req_tlast) queue_ff[wr_ptr_ff + 1'b1] <= summary_res;
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata = {5'd0,
                       queue_ff[rd_ptr_ff].status,
                       queue_ff[rd_ptr_ff].looping,
                       queue_ff[rd_ptr_ff].loop_finish,
                       queue_ff[rd_ptr_ff].loop_begin,
                       queue_ff[rd_ptr_ff].rate_hz,
                       queue_ff[rd_ptr_ff].pcm_value};
   assign rsp_tuser = {queue_ff[rd_ptr_ff].chunk_first, queue_ff[rd_ptr_ff].kind};

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueCountWidth'(QueueDepth))
      else $error("result queue overflow");

   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> count_ff <= QueueCountWidth'(QueueDepth - 2))
      else $error("ready raised without room for two results");

   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> pos_ff == '0 && !in_body_ff && !pad_ff)
      else $error("parser did not restart after final byte");

   a_bad_hdr_idle: assert property (@(posedge clock) disable iff (reset)
      !header_ok_ff |-> !in_body_ff)
      else $error("chunk body walked after header mismatch");

   a_pad_outside_body: assert property (@(posedge clock) disable iff (reset)
      pad_ff |-> !in_body_ff)
      else $error("pad byte pending inside a chunk body");

endmodule

// File: bench/wav_riff_chunk_parser_test.sv
// Testbench for wav_riff_chunk_parser: streams WAV files byte by byte and
// checks every sample and summary item against a scoreboard that predicts them.
// Depends on wrcp_pkg and the parser RTL.
`timescale 1ns / 1ps

module wav_riff_chunk_parser_test
   import wrcp_pkg::*;
();

   // Predicts the parser's samples and summaries and holds them until they arrive.
   class wav_scoreboard;
      result_type pending[$];
      int errors;

      logic [31:0] byte_cnt;
      bit hdr_good;
      logic [31:0] tag_acc;
      logic [31:0] size_reg;
      logic [31:0] offset;
      chunk_kind_type kind;
      bit in_body;
      bit pad_due;
      logic [31:0] count_reg;
      logic [31:0] rate;
      logic [31:0] lbeg;
      logic [31:0] lfin;
      bit loop_on;
      bit got_data;
      logic [31:0] shift_acc;
      logic [31:0] begin_save;

      function new();
         errors = 0;
         clear();
      endfunction

      function void clear();
         byte_cnt = '0;
         hdr_good = 1'b1;
         tag_acc = '0;
         size_reg = '0;
         offset = '0;
         kind = KIND_OTHER;
         in_body = 1'b0;
         pad_due = 1'b0;
         count_reg = '0;
         rate = '0;
         lbeg = '0;
         lfin = '0;
         loop_on = 1'b0;
         got_data = 1'b0;
         shift_acc = '0;
         begin_save = '0;
      endfunction

      task report(input string what, input logic [31:0] got, input logic [31:0] want);
         $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
         errors++;
      endtask

      function void note_byte(input logic [7:0] b, input logic last);
         result_type r;
         bit emit;
         bit first;
         logic [31:0] off;
         emit = 1'b0;
         first = 1'b0;
         if (byte_cnt < 32'(PosTagEnd)) begin
            if (byte_cnt < 32'(PosRiffEnd)) begin
               if (b != RiffTag[byte_cnt[1:0]]) hdr_good = 1'b0;
            end else if (byte_cnt >= 32'(PosWaveStart)) begin
               if (b != WaveTag[byte_cnt[1:0]]) hdr_good = 1'b0;
            end
         end else if (hdr_good) begin
            if (pad_due) begin
               pad_due = 1'b0;
            end else if (!in_body) begin
               if (offset < 4) tag_acc = {tag_acc[23:0], b};
               else size_reg = {b, size_reg[31:8]};
               offset++;
               if (offset == 8) begin
                  offset = '0;
                  case (tag_acc)
                     TagFmt:  kind = KIND_FMT;
                     TagSmpl: kind = KIND_SMPL;
                     TagData: kind = KIND_DATA;
                     default: kind = KIND_OTHER;
                  endcase
                  if (kind == KIND_DATA) got_data = 1'b0;
                  in_body = (size_reg != 0);
               end
            end else begin
               off = offset;
               shift_acc = {b, shift_acc[31:8]};
               case (kind)
                  KIND_FMT: begin
                     if (size_reg >= FmtMinLen && off == FmtRateOff) rate = shift_acc;
                  end
                  KIND_SMPL: begin
                     if (size_reg >= SmplMinLen) begin
                        if (off == SmplCountOff) count_reg = shift_acc;
                        if (off == SmplBeginOff) begin_save = shift_acc;
                        if (off == SmplEndOff && count_reg != 0) begin
                           lbeg = begin_save;
                           lfin = shift_acc;
                           loop_on = 1'b1;
                        end
                     end
                  end
                  KIND_DATA: begin
                     emit = 1'b1;
                     first = (off == 0);
                     got_data = 1'b1;
                  end
                  default: ;
               endcase
               if ({1'b0, off} + 33'd1 == {1'b0, size_reg}) begin
                  in_body = 1'b0;
                  offset = '0;
                  pad_due = size_reg[0];
               end else begin
                  offset = off + 1;
               end
            end
         end
         if (byte_cnt != '1) byte_cnt++;

         if (emit) begin
            r = '0;
            r.kind = RES_SAMPLE;
            r.pcm_value = b ^ PcmBias;
            r.chunk_first = first;
            pending.push_back(r);
         end
         if (last) begin
            r = '0;
            r.kind = RES_SUMMARY;
            r.rate_hz = rate;
            r.loop_begin = lbeg;
            r.loop_finish = lfin;
            r.looping = loop_on;
            if (byte_cnt < 32'(MinFileBytes)) r.status = STAT_SHORT;
            else if (!hdr_good) r.status = STAT_BAD_HDR;
            else if (!got_data) r.status = STAT_NO_DATA;
            else r.status = STAT_OK;
            pending.push_back(r);
            clear();
         end
      endfunction

      task check_result(input logic [DataWidth-1:0] data, input logic [1:0] user);
         result_type want;
         if (pending.size() == 0) begin
            report("result with nothing expected", data[31:0], '0);
         end else begin
            want = pending.pop_front();
            if (user[0] != want.kind) report("kind", user[0], want.kind);
            if (user[1] != want.chunk_first) report("chunk_first", user[1], want.chunk_first);
            if (data[7:0] != want.pcm_value) report("pcm_value", data[7:0], want.pcm_value);
            if (data[39:8] != want.rate_hz) report("rate_hz", data[39:8], want.rate_hz);
            if (data[71:40] != want.loop_begin) report("loop_begin", data[71:40], want.loop_begin);
            if (data[103:72] != want.loop_finish)
               report("loop_finish", data[103:72], want.loop_finish);
            if (data[104] != want.looping) report("looping", data[104], want.looping);
            if (data[106:105] != want.status) report("status", data[106:105], want.status);
         end
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [7:0]           req_tdata;   // [7:0] in_byte
   logic                 req_tlast;   // in_last
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   // [7:0] pcm_value, [39:8] rate_hz, [71:40] loop_begin, [103:72] loop_finish,
   // [104] looping, [106:105] status, [111:107] zero
   logic [DataWidth-1:0] rsp_tdata;
   logic [1:0]           rsp_tuser;   // [0] kind, [1] chunk_first

   wav_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   bit hold_request;
   int hold_left;
   int bytes_sent;
   logic [7:0] file_bytes[$];

   wav_riff_chunk_parser i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("wav_riff_chunk_parser_test NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   // Receiver: random stalls, plus a long hold-off on request.
   initial begin
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = 300;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic void put_word(input logic [31:0] w, input bit big_endian);
      for (int i = 0; i < 4; i++)
         file_bytes.push_back(big_endian ? w[31 - 8 * i -: 8] : w[8 * i +: 8]);
   endfunction

   // Build one file: mostly well-formed chunk sequences with random content,
   // some noise, broken headers, truncation and trailing partial headers.
   function automatic void build_file();
      int mode;
      int nchunks;
      int sel;
      int body_n;
      int start;
      int idx;
      int cut;
      logic [31:0] tag;
      logic [31:0] len;
      bit stop;
      bit zero_count;
      file_bytes.delete();
      mode = $urandom_range(99);
      if (mode < 8) begin
         repeat ($urandom_range(1, 60)) file_bytes.push_back(8'($urandom));
         return;
      end
      put_word(32'h5249_4646, 1'b1);
      put_word($urandom, 1'b0);
      put_word(32'h5741_5645, 1'b1);
      if (mode < 16) begin
         idx = $urandom_range(0, 7);
         if (idx >= 4) idx += 4;
         file_bytes[idx] = file_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
      end
      nchunks = $urandom_range(1, 4);
      stop = 1'b0;
      for (int c = 0; c < nchunks && !stop; c++) begin
         sel = $urandom_range(0, 9);
         zero_count = 1'b0;
         if (sel <= 1) begin
            tag = TagFmt;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(16, 24);
         end else if (sel <= 3) begin
            tag = TagSmpl;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 59) : $urandom_range(60, 66);
            zero_count = ($urandom_range(0, 2) == 0);
         end else if (sel <= 7) begin
            tag = TagData;
            len = $urandom_range(0, 24);
         end else if (sel == 8) begin
            tag = $urandom;
            len = $urandom_range(0, 9);
         end else begin
            // huge size: the file ends before the body does
            tag = $urandom_range(0, 1) ? TagData : 32'($urandom);
            len = {24'hFF_FFFF, 8'($urandom)};
            stop = 1'b1;
         end
         put_word(tag, 1'b1);
         put_word(len, 1'b0);
         body_n = stop ? $urandom_range(0, 20) : int'(len);
         start = file_bytes.size();
         repeat (body_n) file_bytes.push_back(8'($urandom));
         if (zero_count && body_n >= 32)
            for (int i = 28; i < 32; i++) file_bytes[start + i] = 8'h00;
         if (!stop && len[0]) file_bytes.push_back(8'($urandom));
      end
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         repeat ($urandom_range(1, 7)) file_bytes.push_back(8'($urandom));
      end else if (sel == 1) begin
         cut = $urandom_range(1, 12);
         repeat (cut) void'(file_bytes.pop_back());
      end
   endfunction

   // Offer one byte; return at the falling edge after it is taken.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(b, last);
      @(negedge clock);
   endtask

   task automatic send_file();
      for (int i = 0; i < file_bytes.size(); i++)
         send_byte(file_bytes[i], i == file_bytes.size() - 1);
      bytes_sent += file_bytes.size();
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      hold_request = 1'b0;
      send_idle_pct = 24;
      recv_idle_pct = 86;
      bytes_sent = 0;
      sb = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // one-byte files at both extremes, a bare header that ends short, a bad tag
      file_bytes = '{8'hFF};
      send_file();
      file_bytes = '{8'h00};
      send_file();
      file_bytes.delete();
      put_word(32'h5249_4646, 1'b1);
      put_word(32'hFFFF_FFFF, 1'b0);
      put_word(32'h5741_5645, 1'b1);
      send_file();
      file_bytes.delete();
      put_word(32'h5249_4647, 1'b1);
      put_word(32'h0000_0000, 1'b0);
      send_file();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 86 : 0;
         recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 24 : 0;
         if (phase == 2) hold_request = 1'b1;
         bytes_sent = 0;
         while (bytes_sent < 330) begin
            build_file();
            send_file();
         end
         // pause the sender until every result is back
         drain();
      end

      repeat (20) @(negedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("wav_riff_chunk_parser_test OK");
      end else begin
         $display("wav_riff_chunk_parser_test NOT OK");
      end
      $finish;
   end

endmodule
